// ----- design/hrrq_pkg.sv -----
// shared types and constants of the ready-queue scheduler
package hrrq_pkg;

  localparam int PID_W   = 8;
  localparam int EST_W   = 16;
  localparam int NOW_W   = 32;
  localparam int ALPHA_W = 9;
  localparam int FRAC_W  = 8;
  localparam int PROD_W  = ALPHA_W + EST_W;
  localparam int SUM_W   = PROD_W + 1;

  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [SUM_W-1:0]   EST_ROUND   = 26'd128;
  localparam logic [EST_W-1:0]   EST_MIN     = 16'd1;

  localparam logic               MODE_RESET  = 1'b1;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
  localparam logic [EST_W-1:0]   INIT_RESET  = 16'd10000;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_ALPHA = 2'd1,
    REG_INIT  = 2'd2
  } reg_e;

  typedef enum logic {
    REQ_ADMIT    = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_ADMITTED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  localparam logic MODE_FIFO = 1'b0;

  typedef struct packed {
    logic               mode;
    logic [ALPHA_W-1:0] alpha;
    logic [EST_W-1:0]   init_est;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic idx_inc;
    logic ram_rd;
    logic load;
    logic sum;
    logic mul;
    logic cmp;
    logic est_mul;
    logic est_sum;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic dispatch;
    logic idx_end;
    logic slot_valid;
    logic have_best;
    logic hrrn;
    logic out_free;
  } sts_t;

endpackage

// ----- design/hrrq_in_if.sv -----
// request channel: valid/ready handshake with the request word
interface hrrq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [hrrq_pkg::PID_W-1:0]  process_id;
  logic [hrrq_pkg::EST_W-1:0]  last_burst;
  logic [hrrq_pkg::EST_W-1:0]  previous_estimate;
  logic [hrrq_pkg::NOW_W-1:0]  now_time;

  modport source (
    output valid, req_type, process_id, last_burst, previous_estimate, now_time,
    input  ready
  );
  modport sink (
    input  valid, req_type, process_id, last_burst, previous_estimate, now_time,
    output ready
  );
endinterface

// ----- design/hrrq_out_if.sv -----
// response channel: valid/ready handshake with the result word
interface hrrq_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [hrrq_pkg::PID_W-1:0]  chosen_id;
  logic [hrrq_pkg::EST_W-1:0]  chosen_estimate;

  modport source (
    output valid, status, chosen_id, chosen_estimate,
    input  ready
  );
  modport sink (
    input  valid, status, chosen_id, chosen_estimate,
    output ready
  );
endinterface

// ----- design/hrrn_ready_queue_scheduler.sv -----
// top level: apb register file, sequencer and datapath of the ready-queue scheduler
//
// Ready-queue scheduler with SLOTS process slots. An admit word takes the lowest free slot
// and stores id, admission time and an exponentially averaged burst estimate; a dispatch
// word removes the oldest process (mode 0) or the one with the highest response ratio
// (mode 1, exact cross-multiplied compare, lowest slot wins ties). One word is worked on
// at a time; the result register lets the next request in while a result waits. The slot
// scan steps one slot per cycle over the slots it passes and reads the slot memory through
// its single read port: an admit scans to the first free slot and runs the estimate multiply
// and sum steps, or reports the table full; a dispatch loads and compares each occupied
// slot, and in ratio mode each one after the first also passes the sum and split multiply
// steps of the ratio compare.
// Registers sit at byte addresses 0 (mode), 4 (alpha, q1.8) and 8 (initial estimate).
module hrrn_ready_queue_scheduler #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hrrq_pkg::APB_AW-1:0]   paddr,
  input  logic [hrrq_pkg::APB_DW-1:0]   pwdata,
  output logic [hrrq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  hrrq_in_if.sink                       req_i,
  hrrq_out_if.source                    rsp_o
);

  hrrq_pkg::cfg_t cfg_q;
  hrrq_pkg::cmd_t cmd;
  hrrq_pkg::sts_t sts;
  hrrq_pkg::reg_e reg_sel;
  logic           cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = hrrq_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= hrrq_pkg::MODE_RESET;
      cfg_q.alpha    <= hrrq_pkg::ALPHA_RESET;
      cfg_q.init_est <= hrrq_pkg::INIT_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        hrrq_pkg::REG_MODE:  cfg_q.mode     <= pwdata[0];
        hrrq_pkg::REG_ALPHA: cfg_q.alpha    <= pwdata[hrrq_pkg::ALPHA_W-1:0];
        hrrq_pkg::REG_INIT:  cfg_q.init_est <= pwdata[hrrq_pkg::EST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      hrrq_pkg::REG_MODE:  prdata = hrrq_pkg::APB_DW'(cfg_q.mode);
      hrrq_pkg::REG_ALPHA: prdata = hrrq_pkg::APB_DW'(cfg_q.alpha);
      hrrq_pkg::REG_INIT:  prdata = hrrq_pkg::APB_DW'(cfg_q.init_est);
      default:             prdata = '0;
    endcase
  end

  hrrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hrrq_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_i               (cfg_q),
    .req_type_i          (req_i.req_type),
    .process_id_i        (req_i.process_id),
    .last_burst_i        (req_i.last_burst),
    .previous_estimate_i (req_i.previous_estimate),
    .now_time_i          (req_i.now_time),
    .out_valid_o         (rsp_o.valid),
    .out_ready_i         (rsp_o.ready),
    .status_o            (rsp_o.status),
    .chosen_id_o         (rsp_o.chosen_id),
    .chosen_estimate_o   (rsp_o.chosen_estimate)
  );

endmodule

// ----- design/hrrq_ram.sv -----
// generic single-port-write ram with registered read
module hrrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/hrrq_ctrl.sv -----
// sequencer: slot scan, estimate and ratio compare steps, result hand-off
module hrrq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hrrq_pkg::sts_t   sts_i,
  output hrrq_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EST_MUL,
    S_EST_SUM,
    S_LOAD,
    S_SUM,
    S_MUL,
    S_CMP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.idx_end) begin
          state_d = S_FINISH;
        end else if (sts_i.dispatch) begin
          if (sts_i.slot_valid) begin
            cmd_o.ram_rd = 1'b1;
            state_d      = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end else if (!sts_i.slot_valid) begin
          state_d = S_EST_MUL;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_EST_MUL: begin
        cmd_o.est_mul = 1'b1;
        state_d       = S_EST_SUM;
      end
      S_EST_SUM: begin
        cmd_o.est_sum = 1'b1;
        state_d       = S_FINISH;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = (sts_i.have_best && sts_i.hrrn) ? S_SUM : S_CMP;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp     = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SCAN;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ----- design/hrrq_dp.sv -----
// datapath: slot table, estimate unit, wait and cross-multiplied ratio compare
module hrrq_dp #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hrrq_pkg::cmd_t               cmd_i,
  output hrrq_pkg::sts_t               sts_o,
  input  hrrq_pkg::cfg_t               cfg_i,
  input  logic                         req_type_i,
  input  logic [hrrq_pkg::PID_W-1:0]   process_id_i,
  input  logic [hrrq_pkg::EST_W-1:0]   last_burst_i,
  input  logic [hrrq_pkg::EST_W-1:0]   previous_estimate_i,
  input  logic [hrrq_pkg::NOW_W-1:0]   now_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [hrrq_pkg::PID_W-1:0]   chosen_id_o,
  output logic [hrrq_pkg::EST_W-1:0]   chosen_estimate_o
);

  localparam int IW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int XW  = TIME_BITS + 1;
  localparam int HW  = (XW + 1) / 2;
  localparam int PW  = HW + hrrq_pkg::EST_W;
  localparam int FW  = 2 * HW + hrrq_pkg::EST_W;
  localparam int RW  = hrrq_pkg::PID_W + hrrq_pkg::EST_W + TIME_BITS;

  // request word
  hrrq_pkg::req_e                 req_q;
  logic [hrrq_pkg::PID_W-1:0]     pid_q;
  logic [hrrq_pkg::EST_W-1:0]     last_q;
  logic [hrrq_pkg::EST_W-1:0]     prev_q;
  logic [TIME_BITS-1:0]           now_q;

  logic [CW-1:0]                  idx_q;
  logic [IW-1:0]                  slot_idx;
  logic                           idx_end;
  logic [SLOTS-1:0]               valid_q;

  // estimate unit
  logic [hrrq_pkg::ALPHA_W-1:0]   alpha_sat;
  logic [hrrq_pkg::PROD_W-1:0]    prod_a_q, prod_b_q;
  logic [hrrq_pkg::SUM_W-1:0]     est_sum;
  logic [hrrq_pkg::EST_W-1:0]     est_raw;
  logic [hrrq_pkg::EST_W-1:0]     est_q;

  // scan candidate
  logic [RW-1:0]                  rdata;
  logic [RW-1:0]                  wdata;
  logic [TIME_BITS-1:0]           w_q;
  logic [hrrq_pkg::EST_W-1:0]     cur_est_q;
  logic [hrrq_pkg::PID_W-1:0]     cur_pid_q;
  logic [XW-1:0]                  x_q;

  // ratio compare
  logic [2*HW-1:0]                xa, xb;
  logic [PW-1:0]                  pa_lo_q, pa_hi_q, pb_lo_q, pb_hi_q;
  logic [FW-1:0]                  full_a, full_b;
  logic                           take;

  // best so far
  logic                           have_best_q;
  logic [IW-1:0]                  best_idx_q;
  logic [TIME_BITS-1:0]           best_wait_q;
  logic [hrrq_pkg::EST_W-1:0]     best_est_q;
  logic [hrrq_pkg::PID_W-1:0]     best_pid_q;
  logic [XW-1:0]                  best_x_q;

  // result register
  logic                           out_valid_q;
  logic                           out_free;
  hrrq_pkg::status_e              res_status, out_status_q;
  logic [hrrq_pkg::PID_W-1:0]     res_id, out_id_q;
  logic [hrrq_pkg::EST_W-1:0]     res_est, out_est_q;
  logic                           ram_we;

  assign slot_idx = idx_q[IW-1:0];
  assign idx_end  = (idx_q == CW'(SLOTS));
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.dispatch   = (req_q == hrrq_pkg::REQ_DISPATCH);
  assign sts_o.idx_end    = idx_end;
  assign sts_o.slot_valid = valid_q[slot_idx];
  assign sts_o.have_best  = have_best_q;
  assign sts_o.hrrn       = (cfg_i.mode != hrrq_pkg::MODE_FIFO);
  assign sts_o.out_free   = out_free;

  // estimate
  assign alpha_sat = (cfg_i.alpha > hrrq_pkg::ALPHA_ONE) ? hrrq_pkg::ALPHA_ONE : cfg_i.alpha;
  assign est_sum   = hrrq_pkg::SUM_W'(prod_a_q) + hrrq_pkg::SUM_W'(prod_b_q)
                   + hrrq_pkg::EST_ROUND;
  assign est_raw   = (last_q == '0) ? cfg_i.init_est
                   : est_sum[hrrq_pkg::FRAC_W +: hrrq_pkg::EST_W];

  // ratio compare: (wa+ea)*eb against (wb+eb)*ea in two halves
  assign xa     = (2*HW)'(x_q);
  assign xb     = (2*HW)'(best_x_q);
  assign full_a = (FW'(pa_hi_q) << HW) + FW'(pa_lo_q);
  assign full_b = (FW'(pb_hi_q) << HW) + FW'(pb_lo_q);

  always_comb begin
    if (!have_best_q) begin
      take = 1'b1;
    end else if (cfg_i.mode == hrrq_pkg::MODE_FIFO) begin
      take = (w_q > best_wait_q);
    end else begin
      take = (full_a > full_b);
    end
  end

  // result word
  always_comb begin
    res_id  = '0;
    res_est = '0;
    if (req_q == hrrq_pkg::REQ_ADMIT) begin
      if (idx_end) begin
        res_status = hrrq_pkg::ST_FULL;
      end else begin
        res_status = hrrq_pkg::ST_ADMITTED;
        res_est    = est_q;
      end
    end else if (have_best_q) begin
      res_status = hrrq_pkg::ST_DISPATCHED;
      res_id     = best_pid_q;
      res_est    = best_est_q;
    end else begin
      res_status = hrrq_pkg::ST_EMPTY;
    end
  end

  assign ram_we = cmd_i.finish && (req_q == hrrq_pkg::REQ_ADMIT) && !idx_end;
  assign wdata  = {pid_q, est_q, now_q};

  hrrq_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_idx),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (slot_idx),
    .rdata_o (rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q       <= hrrq_pkg::REQ_ADMIT;
      idx_q       <= '0;
      valid_q     <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        req_q       <= hrrq_pkg::req_e'(req_type_i);
        idx_q       <= '0;
        have_best_q <= 1'b0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.cmp && take) begin
        have_best_q <= 1'b1;
      end
      if (ram_we) begin
        valid_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.finish && (req_q == hrrq_pkg::REQ_DISPATCH) && have_best_q) begin
        valid_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pid_q  <= process_id_i;
      last_q <= last_burst_i;
      prev_q <= previous_estimate_i;
      now_q  <= TIME_BITS'(now_time_i);
    end
    if (cmd_i.est_mul) begin
      prod_a_q <= hrrq_pkg::PROD_W'(alpha_sat) * hrrq_pkg::PROD_W'(last_q);
      prod_b_q <= hrrq_pkg::PROD_W'(hrrq_pkg::ALPHA_ONE - alpha_sat)
                * hrrq_pkg::PROD_W'(prev_q);
    end
    if (cmd_i.est_sum) begin
      est_q <= (est_raw == '0) ? hrrq_pkg::EST_MIN : est_raw;
    end
    if (cmd_i.load) begin
      w_q       <= now_q - rdata[TIME_BITS-1:0];
      cur_est_q <= rdata[TIME_BITS +: hrrq_pkg::EST_W];
      cur_pid_q <= rdata[TIME_BITS + hrrq_pkg::EST_W +: hrrq_pkg::PID_W];
    end
    if (cmd_i.sum) begin
      x_q <= XW'(w_q) + XW'(cur_est_q);
    end
    if (cmd_i.mul) begin
      pa_lo_q <= PW'(xa[HW-1:0])    * PW'(best_est_q);
      pa_hi_q <= PW'(xa[2*HW-1:HW]) * PW'(best_est_q);
      pb_lo_q <= PW'(xb[HW-1:0])    * PW'(cur_est_q);
      pb_hi_q <= PW'(xb[2*HW-1:HW]) * PW'(cur_est_q);
    end
    if (cmd_i.cmp && take) begin
      best_idx_q  <= slot_idx;
      best_wait_q <= w_q;
      best_est_q  <= cur_est_q;
      best_pid_q  <= cur_pid_q;
      best_x_q    <= XW'(w_q) + XW'(cur_est_q);
    end
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
      out_est_q    <= res_est;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign chosen_id_o       = out_id_q;
  assign chosen_estimate_o = out_est_q;

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken word");

  a_admit_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(slot_idx)])
    else $error("admitted slot not marked valid");

  a_pick_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && (req_q == hrrq_pkg::REQ_DISPATCH) && have_best_q)
      |-> valid_q[best_idx_q])
    else $error("dispatched slot was not occupied");

  a_best_est: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> (best_est_q != '0))
    else $error("zero estimate in chosen slot");

endmodule
